FILE: sv/lsmt_pkg.sv
// Shared types and constants of the learning switch MAC table.
package lsmt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAC_W       = 48;
    localparam int PORT_W      = 8;
    localparam int AGE_W       = 16;
    localparam int TYPE_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AGING_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE    = 2'd2;

    localparam logic [AGE_W-1:0]  RST_AGING_LIMIT  = 16'd10;
    localparam logic [TYPE_W-1:0] RST_CONTROL_TYPE = 16'd0;
    localparam logic [TYPE_W-1:0] RST_DATA_TYPE    = 16'd2048;

    typedef enum logic [1:0] {
        ACT_FORWARD   = 2'd0,
        ACT_BROADCAST = 2'd1,
        ACT_DROP      = 2'd2
    } t_action;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [AGE_W-1:0]  age;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [AGE_W-1:0]  aging_limit;
        logic [TYPE_W-1:0] control_type;
        logic [TYPE_W-1:0] data_type;
    } t_cfg;

    typedef struct packed {
        t_action           action;
        logic [PORT_W-1:0] out_port;
        logic              table_full;
    } t_result;

endpackage

FILE: sv/lsmt_entry_ram.sv
// Entry memory of the MAC table: one write port, one read port, registered read data.
module lsmt_entry_ram (
    input  logic              i_clk,
    input  lsmt_pkg::t_mem_req i_req,
    output lsmt_pkg::t_entry   o_rdata
);

    lsmt_pkg::t_entry r_mem [lsmt_pkg::TABLE_DEPTH];
    lsmt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lsmt_seq.sv
// Sequencer of the MAC table: scan, learn, refresh and aging sweep over the entry memory.
module lsmt_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lsmt_pkg::t_cfg                   i_cfg,
    input  logic                             i_start,
    input  logic [lsmt_pkg::PORT_W-1:0]      i_port,
    input  logic [lsmt_pkg::MAC_W-1:0]       i_src,
    input  logic [lsmt_pkg::MAC_W-1:0]       i_dst,
    input  logic [lsmt_pkg::TYPE_W-1:0]      i_type,
    output logic                             o_idle,
    output logic                             o_done,
    output lsmt_pkg::t_result                o_result,
    input  logic                             i_take,
    output lsmt_pkg::t_mem_req               o_mem_req,
    input  lsmt_pkg::t_entry                 i_rdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_LEARN = 6'b000100,
        S_AGE   = 6'b001000,
        S_HIT   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                            r_state;
    logic [lsmt_pkg::TABLE_DEPTH-1:0]  r_valid;
    logic [lsmt_pkg::CNT_W-1:0]        r_idx;
    logic                              r_rd_pend;
    logic [lsmt_pkg::IDX_W-1:0]        r_rd_idx;

    logic [lsmt_pkg::PORT_W-1:0]       r_port;
    logic [lsmt_pkg::MAC_W-1:0]        r_src;
    logic [lsmt_pkg::MAC_W-1:0]        r_dst;
    logic [lsmt_pkg::TYPE_W-1:0]       r_type;

    logic                              r_src_hit;
    logic [lsmt_pkg::IDX_W-1:0]        r_src_slot;
    logic [lsmt_pkg::PORT_W-1:0]       r_src_port;
    logic                              r_dst_hit;
    logic [lsmt_pkg::IDX_W-1:0]        r_dst_slot;
    logic [lsmt_pkg::PORT_W-1:0]       r_dst_port;
    logic                              r_free_found;
    logic [lsmt_pkg::IDX_W-1:0]        r_free_slot;

    lsmt_pkg::t_result                 r_result;

    logic                              more_rd;
    logic                              sweep_end;
    logic                              learn_we;
    logic [lsmt_pkg::IDX_W-1:0]        learn_slot;
    logic [lsmt_pkg::PORT_W-1:0]       learn_port;
    logic                              same_mac;
    logic                              dst_hit_eff;
    logic [lsmt_pkg::IDX_W-1:0]        dst_slot_eff;
    logic [lsmt_pkg::PORT_W-1:0]       dst_port_eff;
    logic [lsmt_pkg::AGE_W-1:0]        age_dec;
    logic                              age_we;

    assign more_rd   = r_idx < lsmt_pkg::CNT_W'(lsmt_pkg::TABLE_DEPTH);
    assign sweep_end = !more_rd && !r_rd_pend;

    // A known source keeps its stored port; an unknown one takes the lowest free slot.
    assign learn_we   = r_src_hit || r_free_found;
    assign learn_slot = r_src_hit ? r_src_slot : r_free_slot;
    assign learn_port = r_src_hit ? r_src_port : r_port;

    // When the destination equals the source, the lookup sees the entry just learned.
    assign same_mac     = r_dst == r_src;
    assign dst_hit_eff  = same_mac ? learn_we   : r_dst_hit;
    assign dst_slot_eff = same_mac ? learn_slot : r_dst_slot;
    assign dst_port_eff = same_mac ? learn_port : r_dst_port;

    assign age_dec = i_rdata.age - lsmt_pkg::AGE_W'(1);
    assign age_we  = (r_state == S_AGE) && r_rd_pend && r_valid[r_rd_idx];

    always_comb begin
        o_mem_req = '0;
        case (r_state)
            S_SCAN: begin
                o_mem_req.re    = more_rd;
                o_mem_req.raddr = r_idx[lsmt_pkg::IDX_W-1:0];
            end
            S_AGE: begin
                o_mem_req.re         = more_rd;
                o_mem_req.raddr      = r_idx[lsmt_pkg::IDX_W-1:0];
                o_mem_req.we         = age_we;
                o_mem_req.waddr      = r_rd_idx;
                o_mem_req.wdata.mac  = i_rdata.mac;
                o_mem_req.wdata.port = i_rdata.port;
                o_mem_req.wdata.age  = age_dec;
            end
            S_LEARN: begin
                o_mem_req.we         = learn_we;
                o_mem_req.waddr      = learn_slot;
                o_mem_req.wdata.mac  = r_src;
                o_mem_req.wdata.port = learn_port;
                o_mem_req.wdata.age  = i_cfg.aging_limit;
            end
            S_HIT: begin
                o_mem_req.we         = 1'b1;
                o_mem_req.waddr      = r_dst_slot;
                o_mem_req.wdata.mac  = r_dst;
                o_mem_req.wdata.port = r_dst_port;
                o_mem_req.wdata.age  = i_cfg.aging_limit;
            end
            default: begin
                o_mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_idx        <= '0;
            r_rd_pend    <= 1'b0;
            r_src_hit    <= 1'b0;
            r_dst_hit    <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_port       <= i_port;
                        r_src        <= i_src;
                        r_dst        <= i_dst;
                        r_type       <= i_type;
                        r_src_hit    <= 1'b0;
                        r_dst_hit    <= 1'b0;
                        r_free_found <= 1'b0;
                        r_idx        <= '0;
                        r_rd_pend    <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= more_rd;
                    r_rd_idx  <= r_idx[lsmt_pkg::IDX_W-1:0];
                    if (more_rd) begin
                        r_idx <= r_idx + lsmt_pkg::CNT_W'(1);
                    end
                    if (r_rd_pend) begin
                        if (r_valid[r_rd_idx]) begin
                            if (!r_src_hit && i_rdata.mac == r_src) begin
                                r_src_hit  <= 1'b1;
                                r_src_slot <= r_rd_idx;
                                r_src_port <= i_rdata.port;
                            end
                            if (!r_dst_hit && i_rdata.mac == r_dst) begin
                                r_dst_hit  <= 1'b1;
                                r_dst_slot <= r_rd_idx;
                                r_dst_port <= i_rdata.port;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_slot  <= r_rd_idx;
                        end
                    end
                    if (sweep_end) begin
                        r_state <= S_LEARN;
                    end
                end
                S_LEARN: begin
                    if (!r_src_hit && r_free_found) begin
                        r_valid[r_free_slot] <= 1'b1;
                    end
                    r_dst_hit           <= dst_hit_eff;
                    r_dst_slot          <= dst_slot_eff;
                    r_dst_port          <= dst_port_eff;
                    r_result.table_full <= !learn_we;
                    r_result.out_port   <= '0;
                    r_idx               <= '0;
                    r_rd_pend           <= 1'b0;
                    if (r_type == i_cfg.control_type) begin
                        r_result.action <= lsmt_pkg::ACT_DROP;
                        r_state         <= S_AGE;
                    end else if (r_type == i_cfg.data_type && dst_hit_eff) begin
                        r_result.action <= lsmt_pkg::ACT_BROADCAST;
                        r_state         <= S_HIT;
                    end else begin
                        r_result.action <= lsmt_pkg::ACT_BROADCAST;
                        r_state         <= S_DONE;
                    end
                end
                S_AGE: begin
                    r_rd_pend <= more_rd;
                    r_rd_idx  <= r_idx[lsmt_pkg::IDX_W-1:0];
                    if (more_rd) begin
                        r_idx <= r_idx + lsmt_pkg::CNT_W'(1);
                    end
                    if (age_we && age_dec == '0) begin
                        r_valid[r_rd_idx] <= 1'b0;
                    end
                    if (sweep_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_HIT: begin
                    if (r_dst_port != r_port) begin
                        r_result.action   <= lsmt_pkg::ACT_FORWARD;
                        r_result.out_port <= r_dst_port;
                    end else begin
                        r_result.action <= lsmt_pkg::ACT_DROP;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = r_state == S_IDLE;
    assign o_done   = r_state == S_DONE;
    assign o_result = r_result;

    // The aging sweep writes one entry while reading the next, never the same one.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_req.we && o_mem_req.re) |-> (o_mem_req.waddr != o_mem_req.raddr))
        else $error("entry memory read and write hit the same slot");

    // Learning into a free slot marks it valid right away.
    a_learn_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEARN && !r_src_hit && r_free_found) |=> r_valid[$past(r_free_slot)])
        else $error("learned slot not marked valid");

    // A full-table flag means the source was neither found nor placed.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_result.table_full) |-> (!r_src_hit && !r_free_found))
        else $error("table_full raised although the source was learned");

    // Only a forwarded frame carries an egress port.
    a_port_only_on_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_result.action != lsmt_pkg::ACT_FORWARD)
        |-> (r_result.out_port == '0))
        else $error("nonzero out_port on a frame that is not forwarded");

endmodule

FILE: sv/learning_switch_mac_table.sv
// Top level of the learning switch MAC table: configuration, request channels and result register.
//
//   channel   direction  handshake                   payload
//   in        request    i_in_valid / o_in_ready     i_in_port, i_src_mac, i_dst_mac, i_frame_type
//   out       result     o_out_valid / i_out_ready   o_action, o_out_port, o_table_full
//   cfg       write      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One request is processed at a time. Every request first sweeps all TABLE_DEPTH entries
// of the entry memory (one read per cycle plus the read latency) to find the source, the
// destination and the lowest free slot, then writes the learned or refreshed source entry
// unless the table is full. A control frame adds a second read-modify-write sweep that ages
// every valid entry; a data frame that hits adds one write to refresh the destination entry.
// Reset is synchronous; valid bits are flip-flops cleared at once, so the memory needs no
// clearing pass. A finished result sits in the output register, and a new request is
// accepted while it waits; the sequencer only holds its next result back until the output
// register is empty or being emptied.
module learning_switch_mac_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lsmt_pkg::PORT_W-1:0]         i_in_port,
    input  logic [lsmt_pkg::MAC_W-1:0]          i_src_mac,
    input  logic [lsmt_pkg::MAC_W-1:0]          i_dst_mac,
    input  logic [lsmt_pkg::TYPE_W-1:0]         i_frame_type,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_action,
    output logic [lsmt_pkg::PORT_W-1:0]         o_out_port,
    output logic                                o_table_full,

    input  logic                                i_cfg_we,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lsmt_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    lsmt_pkg::t_result   r_out;

    logic                seq_idle;
    logic                seq_done;
    lsmt_pkg::t_result   seq_result;
    lsmt_pkg::t_mem_req  mem_req;
    lsmt_pkg::t_entry    mem_rdata;
    logic                slot_free;
    logic                load_out;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aging_limit  <= lsmt_pkg::RST_AGING_LIMIT;
            r_cfg.control_type <= lsmt_pkg::RST_CONTROL_TYPE;
            r_cfg.data_type    <= lsmt_pkg::RST_DATA_TYPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsmt_pkg::CFG_AGING_LIMIT:  r_cfg.aging_limit  <= i_cfg_data;
                lsmt_pkg::CFG_CONTROL_TYPE: r_cfg.control_type <= i_cfg_data;
                lsmt_pkg::CFG_DATA_TYPE:    r_cfg.data_type    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The output register takes a result when it is empty or being emptied this cycle.
    assign slot_free = !r_out_valid || i_out_ready;
    assign load_out  = seq_done && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= seq_result;
        end
    end

    lsmt_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_start   (i_in_valid),
        .i_port    (i_in_port),
        .i_src     (i_src_mac),
        .i_dst     (i_dst_mac),
        .i_type    (i_frame_type),
        .o_idle    (seq_idle),
        .o_done    (seq_done),
        .o_result  (seq_result),
        .i_take    (load_out),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    lsmt_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready   = seq_idle;
    assign o_out_valid  = r_out_valid;
    assign o_action     = r_out.action;
    assign o_out_port   = r_out.out_port;
    assign o_table_full = r_out.table_full;

endmodule
